/* hdl/mi_pkg.sv */
// shared constants and types for the modular inverse block
package mi_pkg;

    localparam int DEF_WIDTH = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GROW,
        ST_SHRINK,
        ST_FIX,
        ST_DONE
    } mi_state_t;

endpackage

/* hdl/modular_inverse.sv */
// modular inverse by the extended euclidean algorithm, shift-subtract datapath
//
// usage: drive value and modulus and raise start while busy is low; the request
// is taken at that clock edge and busy rises on the next cycle. when the work is
// over, done is high for exactly one cycle with inverse and exists valid in that
// cycle. busy is already low in that cycle, so a new request may be taken at the
// same edge that takes the result. the receiver cannot stall: a result must be
// taken in its done cycle.
// datapath: each euclid quotient step runs through one comparator and subtractor,
// shifting the divisor up one bit a cycle and back down one bit a cycle. the
// input is first reduced by the modulus with the same step. one request is in
// flight at a time.
// exists is 0 and inverse is 0 for a zero modulus or a gcd other than one; a
// modulus of one gives inverse 0 with exists set.
// reset: rst_n clears the sequencer to idle and drops done; no request is lost
// other than one in progress, which is abandoned.
module modular_inverse #(
    parameter int WIDTH = mi_pkg::DEF_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] value,
    input  logic [WIDTH-1:0] modulus,
    output logic             done,
    output logic [WIDTH-1:0] inverse,
    output logic             exists
);
    import mi_pkg::*;

    mi_state_t state_reg, state_next;

    logic [WIDTH-1:0] m_reg,  m_next;
    logic [WIDTH-1:0] r0_reg, r0_next;
    logic [WIDTH-1:0] r1_reg, r1_next;
    logic [WIDTH:0]   d_reg,  d_next;
    logic [WIDTH-1:0] c0_reg, c0_next;
    logic [WIDTH-1:0] c1_reg, c1_next;
    logic [WIDTH-1:0] cd_reg, cd_next;
    logic             idx_reg, idx_next;
    logic             ok_reg, ok_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] inv_reg, inv_next;
    logic             exists_reg, exists_next;

    // the compare/subtract unit shared by the grow and shrink states
    logic [WIDTH+1:0] cmp_a, cmp_b, diff;
    logic             ge;
    logic             last_bit;
    logic [WIDTH-1:0] rem_new, acc_new, acc_sum, fix_val;

    always_comb
    begin
        cmp_a = {2'b00, r0_reg};
        if (state_reg == ST_GROW)
            cmp_b = {d_reg, 1'b0};
        else
            cmp_b = {1'b0, d_reg};
        ge   = (cmp_a >= cmp_b);
        diff = cmp_a - cmp_b;
    end

    always_comb
    begin
        acc_sum  = c0_reg + cd_reg;
        rem_new  = ge ? diff[WIDTH-1:0] : r0_reg;
        acc_new  = ge ? acc_sum : c0_reg;
        last_bit = (d_reg == {1'b0, r1_reg});
        // odd index: coefficient positive, even: negative or zero
        fix_val  = idx_reg ? c0_reg : (m_reg - c0_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_CHECK;
            ST_CHECK:  state_next = (r1_reg != '0) ? ST_GROW : ST_FIX;
            ST_GROW:   if (!ge) state_next = ST_SHRINK;
            ST_SHRINK: if (last_bit) state_next = ST_CHECK;
            ST_FIX:    state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        m_next      = m_reg;
        r0_next     = r0_reg;
        r1_next     = r1_reg;
        d_next      = d_reg;
        c0_next     = c0_reg;
        c1_next     = c1_reg;
        cd_next     = cd_reg;
        idx_next    = idx_reg;
        ok_next     = ok_reg;
        done_next   = 1'b0;
        inv_next    = inv_reg;
        exists_next = exists_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // first step reduces value by the modulus, coefficients set
                    // so that after the swap c0 = 0, c1 = 1 and index is even
                    m_next   = modulus;
                    r0_next  = value;
                    r1_next  = modulus;
                    c0_next  = {{(WIDTH-1){1'b0}}, 1'b1};
                    c1_next  = '0;
                    idx_next = 1'b1;
                end
            end
            ST_CHECK:
            begin
                d_next  = {1'b0, r1_reg};
                cd_next = c1_reg;
            end
            ST_GROW:
            begin
                if (ge)
                begin
                    d_next  = {d_reg[WIDTH-1:0], 1'b0};
                    cd_next = {cd_reg[WIDTH-2:0], 1'b0};
                end
            end
            ST_SHRINK:
            begin
                if (last_bit)
                begin
                    r0_next  = r1_reg;
                    r1_next  = rem_new;
                    c0_next  = c1_reg;
                    c1_next  = acc_new;
                    idx_next = ~idx_reg;
                end
                else
                begin
                    r0_next = rem_new;
                    c0_next = acc_new;
                    d_next  = {1'b0, d_reg[WIDTH:1]};
                    cd_next = {1'b0, cd_reg[WIDTH-1:1]};
                end
            end
            ST_FIX:
            begin
                ok_next = (r0_reg == {{(WIDTH-1){1'b0}}, 1'b1}) && (m_reg != '0);
                r1_next = fix_val;
            end
            ST_DONE:
            begin
                done_next   = 1'b1;
                exists_next = ok_reg;
                if (!ok_reg)
                    inv_next = '0;
                else if (r1_reg >= m_reg)
                    inv_next = r1_reg - m_reg;
                else
                    inv_next = r1_reg;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        r0_reg     <= r0_next;
        r1_reg     <= r1_next;
        d_reg      <= d_next;
        c0_reg     <= c0_next;
        c1_reg     <= c1_next;
        cd_reg     <= cd_next;
        idx_reg    <= idx_next;
        ok_reg     <= ok_next;
        inv_reg    <= inv_next;
        exists_reg <= exists_next;
    end

    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign inverse = inv_reg;
    assign exists  = exists_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but sequencer did not start");

    a_no_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !exists) |-> (inverse == '0))
        else $error("nonzero inverse without exists");

    a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && exists) |-> (inverse < m_reg))
        else $error("inverse not reduced below modulus");

    a_grow_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHRINK && $past(state_reg) == ST_GROW) |-> (d_reg[WIDTH] == 1'b0))
        else $error("divisor shifted beyond the remainder width");

endmodule
